[design/tfc_pkg.sv]
package tfc_pkg;

  localparam int TEMP_W = 18;
  localparam int FREQ_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = FREQ_W;

  // The positive spread between two thresholds fits TEMP_W bits; twice it needs one more.
  localparam int SPAN_W = TEMP_W;
  localparam int DEN_W = SPAN_W + 1;
  localparam int SLOPE_W = FREQ_W + 2;
  localparam int PROD1_W = FREQ_W + DEN_W;
  localparam int PROD2_W = SLOPE_W + SPAN_W + 1;
  localparam int NUM_W = FREQ_W + DEN_W;
  localparam int QUOT_W = FREQ_W;

  localparam logic signed [TEMP_W-1:0] LOW_THRESHOLD_RST = 18'sd70000;
  localparam logic signed [TEMP_W-1:0] HIGH_THRESHOLD_RST = 18'sd85000;
  localparam logic signed [TEMP_W-1:0] CRITICAL_THRESHOLD_RST = 18'sd95000;
  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 24'd800000;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 24'd3600000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD = 3'd0,
    REG_HIGH_THRESHOLD = 3'd1,
    REG_CRITICAL_THRESHOLD = 3'd2,
    REG_MIN_FREQ = 3'd3,
    REG_MAX_FREQ = 3'd4,
    REG_POLICY_ENABLED = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ZONE_DISABLED = 3'd0,
    ZONE_NORMAL = 3'd1,
    ZONE_LOW = 3'd2,
    ZONE_HIGH = 3'd3,
    ZONE_CRITICAL = 3'd4
  } zone_t;

endpackage

[design/thermal_frequency_cap.sv]
// Thermal frequency cap: maps one temperature sample (millicelsius) to a CPU
// frequency cap in kHz, a write flag and a throttle zone.
//
// Input channel: sample_valid / sample_stall carry temperature. Output channel:
// cap_valid / cap_stall carry cap_khz, cap_write and zone. A transaction
// completes on a rising edge where valid is high and stall is low.
// Configuration: cfg_write, cfg_index and cfg_data write one register per
// cycle; indexes outside the register list are ignored. Write only while the
// pipeline is empty.
//
// The pipeline has one decode stage, one multiply stage, one add stage and
// 24 one-bit divider stages. A new transaction is taken every cycle unless
// the output is stalled and every stage is full; the 24-stage restoring divider sets the
// depth. Every item, even one that needs no division, travels the same path
// (divided by one), so results leave in input order.
//
// When cap_stall holds the output, each stage keeps moving as long as a
// bubble lies ahead of it, so the pipeline compacts and input is refused only
// once every stage is full. Synchronous reset empties the pipeline and loads
// the default thresholds and frequencies with the policy disabled.
module thermal_frequency_cap
  import tfc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic signed [TEMP_W-1:0]    temperature,
  output logic                        cap_valid,
  input  logic                        cap_stall,
  output logic [FREQ_W-1:0]           cap_khz,
  output logic                        cap_write,
  output logic [2:0]                  zone,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int NDIV = QUOT_W;
  localparam int NSTAGE = NDIV + 3;

  // Configuration registers.
  logic signed [TEMP_W-1:0] low_threshold;
  logic signed [TEMP_W-1:0] high_threshold;
  logic signed [TEMP_W-1:0] critical_threshold;
  logic [FREQ_W-1:0] min_freq_khz;
  logic [FREQ_W-1:0] max_freq_khz;
  logic policy_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
      critical_threshold <= CRITICAL_THRESHOLD_RST;
      min_freq_khz <= MIN_FREQ_RST;
      max_freq_khz <= MAX_FREQ_RST;
      policy_enabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOW_THRESHOLD: low_threshold <= $signed(cfg_data[TEMP_W-1:0]);
        REG_HIGH_THRESHOLD: high_threshold <= $signed(cfg_data[TEMP_W-1:0]);
        REG_CRITICAL_THRESHOLD: critical_threshold <= $signed(cfg_data[TEMP_W-1:0]);
        REG_MIN_FREQ: min_freq_khz <= cfg_data[FREQ_W-1:0];
        REG_MAX_FREQ: max_freq_khz <= cfg_data[FREQ_W-1:0];
        REG_POLICY_ENABLED: policy_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage valids and load enables. Stage 0 decodes, 1 multiplies, 2 adds and
  // seeds the divider, 3 and up each retire one quotient bit.
  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !valid[NSTAGE-1] || !cap_stall;
    for (int j = NSTAGE - 2; j >= 0; j--) begin
      adv[j] = !valid[j] || adv[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) begin
        valid[0] <= sample_valid;
      end
      for (int j = 1; j < NSTAGE; j++) begin
        if (adv[j]) begin
          valid[j] <= valid[j-1];
        end
      end
    end
  end

  assign sample_stall = !adv[0];

  // Decode: choose the band and set up num = a*b + c*e and the divisor.
  // Bands that need no ratio put their cap in a with b = 1 and divisor 1.
  logic signed [TEMP_W:0] span_high;
  logic signed [TEMP_W:0] span_low;
  logic signed [TEMP_W:0] dist_crit;
  logic signed [TEMP_W:0] dist_high;
  logic [FREQ_W-1:0] a_next;
  logic [DEN_W-1:0] b_next;
  logic signed [SLOPE_W-1:0] c_next;
  logic [SPAN_W-1:0] e_next;
  logic [DEN_W-1:0] den_next;
  zone_t zone_next;

  always_comb begin
    span_high = {critical_threshold[TEMP_W-1], critical_threshold}
              - {high_threshold[TEMP_W-1], high_threshold};
    span_low = {high_threshold[TEMP_W-1], high_threshold}
             - {low_threshold[TEMP_W-1], low_threshold};
    dist_crit = {critical_threshold[TEMP_W-1], critical_threshold}
              - {temperature[TEMP_W-1], temperature};
    dist_high = {high_threshold[TEMP_W-1], high_threshold}
              - {temperature[TEMP_W-1], temperature};
    a_next = max_freq_khz;
    b_next = DEN_W'(1);
    c_next = '0;
    e_next = '0;
    den_next = DEN_W'(1);
    zone_next = ZONE_NORMAL;
    priority if (!policy_enabled) begin
      a_next = '0;
      zone_next = ZONE_DISABLED;
    end else if (temperature >= critical_threshold) begin
      a_next = min_freq_khz;
      zone_next = ZONE_CRITICAL;
    end else if (temperature >= high_threshold && span_high > 0) begin
      // min*2d + (max - 2*min)*(crit - t), over 2d.
      den_next = {span_high[SPAN_W-1:0], 1'b0};
      a_next = min_freq_khz;
      b_next = {span_high[SPAN_W-1:0], 1'b0};
      c_next = $signed({2'b00, max_freq_khz}) - $signed({1'b0, min_freq_khz, 1'b0});
      e_next = dist_crit[SPAN_W-1:0];
      zone_next = ZONE_HIGH;
    end else if (temperature >= low_threshold && span_low > 0) begin
      // max*(d + (high - t)), over 2d.
      den_next = {span_low[SPAN_W-1:0], 1'b0};
      b_next = {1'b0, span_low[SPAN_W-1:0]} + {1'b0, dist_high[SPAN_W-1:0]};
      zone_next = ZONE_LOW;
    end else begin
      zone_next = ZONE_NORMAL;
    end
  end

  logic [FREQ_W-1:0] s0_a;
  logic [DEN_W-1:0] s0_b;
  logic signed [SLOPE_W-1:0] s0_c;
  logic [SPAN_W-1:0] s0_e;
  logic [DEN_W-1:0] s0_den;
  zone_t s0_zone;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_a <= a_next;
      s0_b <= b_next;
      s0_c <= c_next;
      s0_e <= e_next;
      s0_den <= den_next;
      s0_zone <= zone_next;
    end
  end

  // Multiply stage.
  logic [PROD1_W-1:0] s1_p1;
  logic signed [PROD2_W-1:0] s1_p2;
  logic [DEN_W-1:0] s1_den;
  zone_t s1_zone;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_p1 <= PROD1_W'(s0_a) * PROD1_W'(s0_b);
      s1_p2 <= PROD2_W'(s0_c) * $signed({{(PROD2_W-SPAN_W){1'b0}}, s0_e});
      s1_den <= s0_den;
      s1_zone <= s0_zone;
    end
  end

  // Add stage: the numerator is never negative and stays below den * 2^24, so
  // its upper bits seed the partial remainder directly.
  logic signed [PROD2_W:0] num_sum;
  logic [NUM_W-1:0] num;

  always_comb begin
    num_sum = $signed({{(PROD2_W+1-PROD1_W){1'b0}}, s1_p1})
            + $signed({s1_p2[PROD2_W-1], s1_p2});
    num = num_sum[NUM_W-1:0];
  end

  logic [DEN_W-1:0] rem_q [0:NDIV];
  logic [QUOT_W-1:0] shq_q [0:NDIV];
  logic [DEN_W-1:0] den_q [0:NDIV];
  zone_t zone_q [0:NDIV];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      rem_q[0] <= num[NUM_W-1:QUOT_W];
      shq_q[0] <= num[QUOT_W-1:0];
      den_q[0] <= s1_den;
      zone_q[0] <= s1_zone;
    end
  end

  // Restoring divider: the low numerator bits shift out the top of shq while
  // quotient bits shift in at the bottom.
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [DEN_W:0] trial;
    logic [DEN_W+1:0] diff;

    always_comb begin
      trial = {rem_q[k-1], shq_q[k-1][QUOT_W-1]};
      diff = {1'b0, trial} - {2'b00, den_q[k-1]};
    end

    always_ff @(posedge clk) begin
      if (adv[k+2]) begin
        if (!diff[DEN_W+1]) begin
          rem_q[k] <= diff[DEN_W-1:0];
          shq_q[k] <= {shq_q[k-1][QUOT_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[DEN_W-1:0];
          shq_q[k] <= {shq_q[k-1][QUOT_W-2:0], 1'b0};
        end
        den_q[k] <= den_q[k-1];
        zone_q[k] <= zone_q[k-1];
      end
    end
  end

  assign cap_valid = valid[NSTAGE-1];
  assign cap_khz = shq_q[NDIV];
  assign zone = zone_q[NDIV];
  assign cap_write = (zone_q[NDIV] != ZONE_DISABLED);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import tfc_pkg::*;

  // Index that lies past the register list; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_SETTINGS = 5;
  localparam int SAMPLES_PER_SETTING = 110;

  // Keeps its own copy of the register file, works out the cap that each
  // accepted temperature should produce and compares results in order.
  class cap_checker;
    typedef struct {
      logic [FREQ_W-1:0] khz;
      logic              wr;
      zone_t             zn;
    } cap_result_t;

    logic signed [TEMP_W-1:0] low_thr, high_thr, crit_thr;
    logic [FREQ_W-1:0]        min_f, max_f;
    logic                     enabled;
    cap_result_t              expected_caps[$];
    int                       errors;
    int                       samples;
    int                       zone_hits[5];

    function new();
      low_thr = LOW_THRESHOLD_RST;
      high_thr = HIGH_THRESHOLD_RST;
      crit_thr = CRITICAL_THRESHOLD_RST;
      min_f = MIN_FREQ_RST;
      max_f = MAX_FREQ_RST;
      enabled = 1'b0;
      errors = 0;
      samples = 0;
      foreach (zone_hits[i]) zone_hits[i] = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOW_THRESHOLD: low_thr = data[TEMP_W-1:0];
        REG_HIGH_THRESHOLD: high_thr = data[TEMP_W-1:0];
        REG_CRITICAL_THRESHOLD: crit_thr = data[TEMP_W-1:0];
        REG_MIN_FREQ: min_f = data[FREQ_W-1:0];
        REG_MAX_FREQ: max_f = data[FREQ_W-1:0];
        REG_POLICY_ENABLED: enabled = data[0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [TEMP_W-1:0] t);
      longint      tv, lo, hi, cr, mn, mx, d, num, cap;
      cap_result_t e;
      tv = t;
      lo = low_thr;
      hi = high_thr;
      cr = crit_thr;
      mn = min_f;
      mx = max_f;
      if (!enabled) begin
        e.khz = '0;
        e.wr = 1'b0;
        e.zn = ZONE_DISABLED;
      end else begin
        cap = mx;
        e.zn = ZONE_NORMAL;
        if (tv >= cr) begin
          cap = mn;
          e.zn = ZONE_CRITICAL;
        end else if (tv >= hi && cr - hi > 0) begin
          d = cr - hi;
          num = mn * 2 * d + (mx - 2 * mn) * (cr - tv);
          if (num < 0) num = 0;
          cap = num / (2 * d);
          e.zn = ZONE_HIGH;
        end else if (tv >= lo && hi - lo > 0) begin
          d = hi - lo;
          num = mx * (d + (hi - tv));
          if (num < 0) num = 0;
          cap = num / (2 * d);
          e.zn = ZONE_LOW;
        end
        if (cap < 0) cap = 0;
        if (cap > longint'(24'hFFFFFF)) cap = 24'hFFFFFF;
        e.khz = cap[FREQ_W-1:0];
        e.wr = 1'b1;
      end
      zone_hits[e.zn]++;
      samples++;
      expected_caps = {expected_caps, e};
    endfunction

    function void check_cap(logic [FREQ_W-1:0] khz, logic wr, logic [2:0] zn);
      cap_result_t e;
      if (expected_caps.size() == 0) begin
        $display("%0t: result with no sample pending: cap_khz %0d cap_write %0b zone %0d",
                 $time, khz, wr, zn);
        errors++;
        return;
      end
      e = expected_caps.pop_front();
      if (khz !== e.khz) begin
        $display("%0t: cap_khz expected %0d, got %0d", $time, e.khz, khz);
        errors++;
      end
      if (wr !== e.wr) begin
        $display("%0t: cap_write expected %0b, got %0b", $time, e.wr, wr);
        errors++;
      end
      if (zn !== e.zn) begin
        $display("%0t: zone expected %0d, got %0d", $time, e.zn, zn);
        errors++;
      end
    endfunction

    function int pending();
      return expected_caps.size();
    endfunction
  endclass

  bit                       clk;
  logic                     rst;
  logic                     sample_valid;
  logic                     sample_stall;
  logic signed [TEMP_W-1:0] temperature;
  logic                     cap_valid;
  logic                     cap_stall;
  logic [FREQ_W-1:0]        cap_khz;
  logic                     cap_write;
  logic [2:0]               zone;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  cap_checker sb;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_cycles;
  int         cycle_count;
  int         settings_used;
  int         cur_thr[3];

  // Temperatures at the range ends, zero, band midpoints and the default band edges with their neighbours.
  int band_edges[12] = '{-131072, 131071, 0, 69999, 70000, 77500,
                         84999, 85000, 90000, 94999, 95000, 95001};

  thermal_frequency_cap i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .temperature  (temperature),
    .cap_valid    (cap_valid),
    .cap_stall    (cap_stall),
    .cap_khz      (cap_khz),
    .cap_write    (cap_write),
    .zone         (zone),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The cycle counter bounds the run in case the pipeline hangs or loses items.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // Both monitors look at the channels on the rising edge. All inputs move on
  // the falling edge, so the sampled values are stable here.
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) sb.note_sample(temperature);
  end

  always @(posedge clk) begin
    if (!rst && cap_valid && !cap_stall) sb.check_cap(cap_khz, cap_write, zone);
  end

  // The result side stalls at random, unless a long hold has been requested.
  // During a hold the pipeline fills up and the block has to refuse input.
  initial begin
    cap_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        cap_stall <= 1'b1;
        hold_cycles--;
      end else begin
        cap_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offers one temperature and returns on the falling edge after the
  // transaction. Valid stays high between back-to-back transactions.
  task automatic send_sample(input logic signed [TEMP_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    temperature <= t;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.apply_reg(idx, data);
    @(negedge clk);
  endtask

  // Registers may only change with the pipeline empty, so wait for every
  // outstanding cap first and then give the block its full depth to settle.
  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all six registers plus the unused index. The upper data bits carry
  // noise so that masking to the register width is exercised as well.
  task automatic configure(input int lo, input int hi, input int cr,
                           input int mn, input int mx, input int en);
    wait_idle();
    write_reg(REG_LOW_THRESHOLD, {6'($urandom), 18'(lo)});
    write_reg(REG_HIGH_THRESHOLD, {6'($urandom), 18'(hi)});
    write_reg(REG_CRITICAL_THRESHOLD, {6'($urandom), 18'(cr)});
    write_reg(REG_MIN_FREQ, 24'(mn));
    write_reg(REG_MAX_FREQ, 24'(mx));
    write_reg(REG_POLICY_ENABLED, {23'($urandom), 1'(en)});
    write_reg(REG_UNUSED, 24'($urandom));
    cfg_write <= 1'b0;
    cur_thr[0] = lo;
    cur_thr[1] = hi;
    cur_thr[2] = cr;
    settings_used++;
  endtask

  function automatic int pick_freq();
    case ($urandom_range(5))
      0: return 0;
      1: return 24'hFFFFFF;
      2: return 800000 + int'($urandom_range(0, 3000000));
      default: return int'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // Most temperatures land close to one of the current thresholds, where the
  // band decisions and the rounding are the most delicate. The rest span
  // the whole 18-bit range, and out-of-range offsets simply wrap.
  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int anchor;
    anchor = cur_thr[$urandom_range(2)];
    case ($urandom_range(3))
      0: return 18'($urandom);
      1: return 18'(anchor + int'($urandom_range(0, 6)) - 3);
      default: return 18'(anchor + int'($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  // Mostly ordered thresholds with an occasional tie, plus some unordered
  // sets so that the band tests fall through to the next one.
  task automatic random_config();
    int                       th[$];
    int                       v;
    logic signed [TEMP_W-1:0] rv;
    repeat (3) begin
      rv = 18'($urandom);
      case ($urandom_range(5))
        0: v = -131072;
        1: v = 131071;
        2: v = 40000 + int'($urandom_range(0, 60000));
        default: v = rv;
      endcase
      th = {th, v};
    end
    if ($urandom_range(3) != 0) th.sort();
    if ($urandom_range(9) == 0) th[1] = th[0];
    if ($urandom_range(9) == 0) th[2] = th[1];
    configure(th[0], th[1], th[2], pick_freq(), pick_freq(), $urandom_range(6) != 0);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    sample_valid = 1'b0;
    temperature = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_cycles = 0;
    cycle_count = 0;
    settings_used = 0;
    send_idle_pct = 24;
    recv_idle_pct = 74;
    cur_thr = '{70000, 85000, 95000};
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of reset the policy is off, so every cap comes back as zero.
    send_sample(-131072);
    send_sample(131071);
    send_sample(0);

    // Default thresholds with the policy on: walk across every band edge.
    configure(70000, 85000, 95000, 800000, 3600000, 1);
    foreach (band_edges[i]) send_sample(band_edges[i]);

    // Reversed thresholds: neither band has a positive width, so anything
    // below critical is treated as normal.
    configure(50000, 40000, 30000, 0, 24'hFFFFFF, 1);
    send_sample(29999);
    send_sample(30000);
    send_sample(45000);
    send_sample(60000);

    // Minimum above half the maximum: the high band climbs toward the minimum.
    configure(-1000, 0, 1000, 3000000, 4000000, 1);
    send_sample(-1000);
    send_sample(-1);
    send_sample(0);
    send_sample(500);
    send_sample(999);

    // Three random phases: receiver slow, sender slow, then full speed. The
    // full-speed phase opens with a long output hold to fill the pipeline.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int c = 0; c < RANDOM_SETTINGS; c++) begin
        random_config();
        if (phase == 2 && c == 0) hold_cycles = 120;
        repeat (SAMPLES_PER_SETTING) send_sample(pick_temp());
      end
    end

    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d temperature samples over %0d register settings, with idling",
             sb.samples, settings_used);
    $display("on both sides and one long output hold; zone counts %0d/%0d/%0d/%0d/%0d",
             sb.zone_hits[ZONE_DISABLED], sb.zone_hits[ZONE_NORMAL], sb.zone_hits[ZONE_LOW],
             sb.zone_hits[ZONE_HIGH], sb.zone_hits[ZONE_CRITICAL]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
